// ===== design/tte_pkg.sv =====
// Package for the token expiry table: sizes, codes, payload and entry types.
// No dependencies; used by every module in design/ except tte_ram.
package tte_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_BITS    = 40;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned TIME_W      = 31;
  localparam int unsigned TTL_W       = 31;
  localparam int unsigned EXP_W       = 32;
  localparam int unsigned LIVE_W      = 11;
  localparam int unsigned ENTRY_W     = 1 + KEY_BITS + EXP_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [TTL_W-1:0]  TTL_RESET = TTL_W'(1);

  typedef enum logic [1:0] {
    REQ_GENERATE = 2'd0,
    REQ_RENEW    = 2'd1,
    REQ_COUNT    = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [KEY_BITS-1:0] token_key;
    logic [TIME_W-1:0]   current_time;
  } req_t;

  typedef struct packed {
    logic [LIVE_W-1:0] live_count;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [EXP_W-1:0]    expiry;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic acc;
  } eval_ctl_t;

  typedef struct packed {
    logic              live;
    logic              match;
    logic [LIVE_W-1:0] count;
  } eval_sts_t;

endpackage

// ===== design/ttl_token_expiry_table.sv =====
// Top level of the token expiry table: time-to-live register, sequencer,
// slot evaluator and table RAM. Depends on tte_pkg, tte_ram, tte_eval, tte_ctrl.
//
// Usage: a request word (req_i) is taken at a rising edge with start high and
// busy low. Request types: generate (store key with expiry now + TTL in the
// lowest empty or expired slot), renew (push expiry of the lowest slot holding
// the key, if still live) and count (number of live slots).
// Every request scans the table through one read port of the table RAM, one
// slot per cycle with one compare unit, up to the last slot or until a generate
// or renew hits; the result word appears on rsp_o with rsp_valid_o high for
// exactly one cycle. A new request may be started in the cycle the result
// is shown. The receiver cannot stall; results must be taken when shown.
// The user writes time_to_live (cfg_we_i / cfg_wdata_i) only while idle;
// the block does not enforce it. Reset value 1. After reset a clear sweep
// writes every slot empty, one slot per cycle, with busy high until it ends.
module ttl_token_expiry_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  tte_pkg::req_t             req_i,
  output logic                      rsp_valid_o,
  output tte_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [tte_pkg::TTL_W-1:0] cfg_wdata_i
);

  logic [tte_pkg::TTL_W-1:0]    ttl_q;
  logic                         ram_we;
  logic [tte_pkg::ADDR_W-1:0]   ram_waddr;
  tte_pkg::entry_t              ram_wdata;
  logic                         ram_re;
  logic [tte_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tte_pkg::ENTRY_W-1:0]  ram_rdata;
  tte_pkg::eval_ctl_t           eval_ctl;
  tte_pkg::eval_sts_t           eval_sts;
  logic [tte_pkg::KEY_BITS-1:0] scan_key;
  logic [tte_pkg::TIME_W-1:0]   scan_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= tte_pkg::TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .ttl_i       (ttl_q),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .eval_ctl_o  (eval_ctl),
    .key_o       (scan_key),
    .now_o       (scan_now),
    .eval_sts_i  (eval_sts)
  );

  tte_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (eval_ctl),
    .entry_i (tte_pkg::entry_t'(ram_rdata)),
    .key_i   (scan_key),
    .now_i   (scan_now),
    .sts_o   (eval_sts)
  );

  tte_ram #(
    .WIDTH (tte_pkg::ENTRY_W),
    .DEPTH (tte_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== design/tte_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tte_eval.sv =====
// Shared slot evaluator: expiry and key compare on the word read from the table,
// plus the live-entry accumulator. Depends on tte_pkg.
module tte_eval (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tte_pkg::eval_ctl_t           ctl_i,
  input  tte_pkg::entry_t              entry_i,
  input  logic [tte_pkg::KEY_BITS-1:0] key_i,
  input  logic [tte_pkg::TIME_W-1:0]   now_i,
  output tte_pkg::eval_sts_t           sts_o
);

  logic [tte_pkg::LIVE_W-1:0] cnt_q, cnt_d;
  logic                       live;
  logic                       match;
  logic [tte_pkg::LIVE_W-1:0] cnt_sum;

  assign live    = entry_i.valid && (entry_i.expiry > tte_pkg::EXP_W'(now_i));
  assign match   = entry_i.valid && (entry_i.key == key_i);
  assign cnt_sum = cnt_q + tte_pkg::LIVE_W'(ctl_i.acc && live);

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clr) begin
      cnt_d = '0;
    end else if (ctl_i.acc) begin
      cnt_d = cnt_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign sts_o.live  = live;
  assign sts_o.match = match;
  assign sts_o.count = cnt_sum;

endmodule

// ===== design/tte_ctrl.sv =====
// Sequencer: post-reset clear sweep, per-request table scan, write-back and result.
// Depends on tte_pkg; drives tte_ram and tte_eval.
module tte_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  tte_pkg::req_t                req_i,
  input  logic [tte_pkg::TTL_W-1:0]    ttl_i,
  output logic                         busy_o,
  output logic                         rsp_valid_o,
  output tte_pkg::rsp_t                rsp_o,
  output logic                         ram_we_o,
  output logic [tte_pkg::ADDR_W-1:0]   ram_waddr_o,
  output tte_pkg::entry_t              ram_wdata_o,
  output logic                         ram_re_o,
  output logic [tte_pkg::ADDR_W-1:0]   ram_raddr_o,
  output tte_pkg::eval_ctl_t           eval_ctl_o,
  output logic [tte_pkg::KEY_BITS-1:0] key_o,
  output logic [tte_pkg::TIME_W-1:0]   now_o,
  input  tte_pkg::eval_sts_t           eval_sts_i
);

  tte_pkg::state_e              state_q, state_d;
  logic [tte_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic                         issued_all_q, issued_all_d;
  logic                         pend_q, pend_d;
  logic [tte_pkg::ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic [1:0]                   req_q, req_d;
  logic [tte_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [tte_pkg::TIME_W-1:0]   now_q, now_d;
  logic [tte_pkg::EXP_W-1:0]    nexp_q, nexp_d;
  tte_pkg::rsp_t                rsp_q, rsp_d;
  logic                         rsp_valid_q, rsp_valid_d;

  logic                         accept;
  logic                         last;
  logic                         fin;
  tte_pkg::status_e             fin_status;

  assign accept = (state_q == tte_pkg::S_IDLE) && start_i;
  assign last   = pend_q && (pend_addr_q == tte_pkg::LAST_ADDR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tte_pkg::S_CLEAR: begin
        if (addr_q == tte_pkg::LAST_ADDR) begin
          state_d = tte_pkg::S_IDLE;
        end
      end
      tte_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = tte_pkg::S_SCAN;
        end
      end
      tte_pkg::S_SCAN: begin
        if (fin) begin
          state_d = tte_pkg::S_IDLE;
        end
      end
      default: state_d = tte_pkg::S_IDLE;
    endcase
  end

  // outputs: table access, evaluator control, end of scan
  always_comb begin
    ram_we_o          = 1'b0;
    ram_waddr_o       = pend_addr_q;
    ram_wdata_o.valid = 1'b1;
    ram_wdata_o.key   = key_q;
    ram_wdata_o.expiry = nexp_q;
    ram_re_o          = 1'b0;
    ram_raddr_o       = addr_q;
    eval_ctl_o        = '0;
    fin               = 1'b0;
    fin_status        = tte_pkg::STAT_DONE;
    case (state_q)
      tte_pkg::S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q;
        ram_wdata_o = '0;
      end
      tte_pkg::S_IDLE: begin
        eval_ctl_o.clr = 1'b1;
      end
      tte_pkg::S_SCAN: begin
        ram_re_o = !issued_all_q;
        if (pend_q) begin
          case (req_q)
            tte_pkg::REQ_GENERATE: begin
              if (!eval_sts_i.live) begin
                ram_we_o = 1'b1;
                fin      = 1'b1;
              end else if (last) begin
                fin        = 1'b1;
                fin_status = tte_pkg::STAT_FULL;
              end
            end
            tte_pkg::REQ_RENEW: begin
              if (eval_sts_i.match) begin
                fin = 1'b1;
                if (eval_sts_i.live) begin
                  ram_we_o = 1'b1;
                end else begin
                  fin_status = tte_pkg::STAT_NO_MATCH;
                end
              end else if (last) begin
                fin        = 1'b1;
                fin_status = tte_pkg::STAT_NO_MATCH;
              end
            end
            tte_pkg::REQ_COUNT: begin
              eval_ctl_o.acc = 1'b1;
              fin            = last;
            end
            default: begin
              fin = last;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    addr_d       = addr_q;
    issued_all_d = issued_all_q;
    pend_d       = 1'b0;
    pend_addr_d  = addr_q;
    req_d        = req_q;
    key_d        = key_q;
    now_d        = now_q;
    nexp_d       = nexp_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = 1'b0;
    if (state_q == tte_pkg::S_CLEAR) begin
      addr_d = addr_q + 1'b1;
    end
    if (accept) begin
      addr_d       = '0;
      issued_all_d = 1'b0;
      req_d        = req_i.req_type;
      key_d        = req_i.token_key;
      now_d        = req_i.current_time;
      nexp_d       = tte_pkg::EXP_W'(req_i.current_time) + tte_pkg::EXP_W'(ttl_i);
    end
    if (state_q == tte_pkg::S_SCAN) begin
      if (!issued_all_q) begin
        addr_d       = addr_q + 1'b1;
        issued_all_d = (addr_q == tte_pkg::LAST_ADDR);
        pend_d       = 1'b1;
      end
      if (fin) begin
        pend_d           = 1'b0;
        rsp_valid_d      = 1'b1;
        rsp_d.status     = fin_status;
        rsp_d.live_count = (req_q == tte_pkg::REQ_COUNT) ? eval_sts_i.count : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tte_pkg::S_CLEAR;
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issued_all_q <= issued_all_d;
      pend_q       <= pend_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    req_q       <= req_d;
    key_q       <= key_d;
    now_q       <= now_d;
    nexp_q      <= nexp_d;
    rsp_q       <= rsp_d;
  end

  assign busy_o      = (state_q != tte_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign key_o       = key_q;
  assign now_o       = now_q;

  a_rsp_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $past(state_q == tte_pkg::S_SCAN))
    else $error("result word without a scan");

  a_write_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::S_SCAN && ram_we_o) |-> fin)
    else $error("table write in mid scan");

  a_count_only_on_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.live_count != '0) |-> (req_q == tte_pkg::REQ_COUNT))
    else $error("live count on non-count request");

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::S_CLEAR) |-> !rsp_valid_q)
    else $error("result word during clear sweep");

endmodule

// ===== tb/sv/tb_ttl_token_expiry_table.sv =====
// Self-checking testbench for ttl_token_expiry_table: directed table, random
// traffic under several TTL settings and idle patterns, then a table-full fill.
// Depends on tte_pkg and the design sources in design/.
`timescale 1ns / 1ps

module tb_ttl_token_expiry_table;
  import tte_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 8_000_000;
  localparam int unsigned POOL_N           = 8;
  localparam int unsigned RANDOM_PER_PHASE = 125;
  localparam logic [TTL_W-1:0]    TTL_MAX  = '1;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [TIME_W-1:0]   NOW_MAX  = '1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_e;

  typedef struct {
    row_e             kind;
    logic [TTL_W-1:0] ttl;
    req_t             rq;
    bit               has_gold;
    rsp_t             gold;
  } drill_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  req_t             req_i       = '0;
  logic             rsp_valid_o;
  rsp_t             rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [TTL_W-1:0] cfg_wdata_i = '0;

  bit                  shadow_valid  [TABLE_DEPTH];
  logic [KEY_BITS-1:0] shadow_key    [TABLE_DEPTH];
  logic [EXP_W-1:0]    shadow_expiry [TABLE_DEPTH];
  logic [TTL_W-1:0]    shadow_ttl = TTL_RESET;

  rsp_t                owed_replies [$];
  rsp_t                due_reply;
  logic [KEY_BITS-1:0] key_pool [POOL_N];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;

  ttl_token_expiry_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit slot_live(int unsigned s, logic [TIME_W-1:0] now);
    return shadow_valid[s] && (shadow_expiry[s] > EXP_W'(now));
  endfunction

  function automatic int unsigned live_slots(logic [TIME_W-1:0] now);
    int unsigned n = 0;
    for (int unsigned s = 0; s < TABLE_DEPTH; s++) begin
      if (slot_live(s, now)) n++;
    end
    return n;
  endfunction

  // Applies one request word to the shadow table and returns the reply word.
  function automatic rsp_t apply_request(req_t rq);
    rsp_t             reply;
    logic [EXP_W-1:0] fresh_expiry;
    reply        = '0;
    reply.status = STAT_DONE;
    fresh_expiry = EXP_W'(rq.current_time) + EXP_W'(shadow_ttl);
    case (req_e'(rq.req_type))
      REQ_GENERATE: begin
        reply.status = STAT_FULL;
        for (int unsigned s = 0; s < TABLE_DEPTH; s++) begin
          if (!slot_live(s, rq.current_time)) begin
            shadow_valid[s]  = 1'b1;
            shadow_key[s]    = rq.token_key;
            shadow_expiry[s] = fresh_expiry;
            reply.status     = STAT_DONE;
            break;
          end
        end
      end
      REQ_RENEW: begin
        reply.status = STAT_NO_MATCH;
        for (int unsigned s = 0; s < TABLE_DEPTH; s++) begin
          if (shadow_valid[s] && shadow_key[s] == rq.token_key) begin
            if (shadow_expiry[s] > EXP_W'(rq.current_time)) begin
              shadow_expiry[s] = fresh_expiry;
              reply.status     = STAT_DONE;
            end
            break;
          end
        end
      end
      REQ_COUNT: begin
        reply.live_count = LIVE_W'(live_slots(rq.current_time));
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic drill_t req_row(req_e kind, logic [KEY_BITS-1:0] key,
                                     logic [TIME_W-1:0] now, bit has_gold = 1'b0,
                                     int unsigned cnt = 0, status_e st = STAT_DONE);
    drill_t row;
    row.kind              = ROW_REQ;
    row.ttl               = '0;
    row.rq.req_type       = kind;
    row.rq.token_key      = key;
    row.rq.current_time   = now;
    row.has_gold          = has_gold;
    row.gold.live_count   = LIVE_W'(cnt);
    row.gold.status       = st;
    return row;
  endfunction

  function automatic drill_t cfg_row(logic [TTL_W-1:0] ttl);
    drill_t row;
    row.kind     = ROW_CFG;
    row.ttl      = ttl;
    row.rq       = '0;
    row.has_gold = 1'b0;
    row.gold     = '0;
    return row;
  endfunction

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(req_t rq, bit has_gold, rsp_t gold);
    rsp_t predicted;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_request(rq);
    owed_replies.push_back(has_gold ? gold : predicted);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (owed_replies.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_ttl(logic [TTL_W-1:0] ttl);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ttl;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_ttl  = ttl;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (owed_replies.size() == 0) begin
        $error("reply word with none owed: live_count %0d status %0d",
               rsp_o.live_count, rsp_o.status);
        mismatch_count++;
      end else begin
        due_reply = owed_replies.pop_front();
        if (rsp_o.live_count !== due_reply.live_count) begin
          $error("live_count: expected %0d, got %0d", due_reply.live_count,
                 rsp_o.live_count);
          mismatch_count++;
        end
        if (rsp_o.status !== due_reply.status) begin
          $error("status: expected %0d, got %0d", due_reply.status, rsp_o.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ttl_token_expiry_table regression: fail");
      $finish;
    end
  end

  initial begin
    drill_t           drills [$];
    drill_t           row;
    int unsigned      idle_pct [4];
    logic [TTL_W-1:0] phase_ttl [4];
    int unsigned      now;
    int unsigned      served;
    int unsigned      pick;
    req_t             rq;

    idle_pct     = '{0, 56, 0, 29};
    phase_ttl[0] = TTL_W'(8);
    phase_ttl[1] = TTL_W'(30);
    phase_ttl[2] = TTL_W'($urandom_range(32'h7FFF_FFFF, 1));
    phase_ttl[3] = TTL_MAX;
    now          = 0;
    foreach (shadow_valid[s]) shadow_valid[s] = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // TTL is 1 out of reset
    drills.push_back(req_row(REQ_COUNT, '0, '0, 1'b1, 0, STAT_DONE));
    drills.push_back(req_row(REQ_RENEW, '0, '0, 1'b1, 0, STAT_NO_MATCH));
    drills.push_back(req_row(REQ_UNUSED, KEY_ONES, NOW_MAX, 1'b1, 0, STAT_DONE));
    drills.push_back(req_row(REQ_GENERATE, '0, '0, 1'b1, 0, STAT_DONE));
    drills.push_back(req_row(REQ_GENERATE, KEY_ONES, '0, 1'b1, 0, STAT_DONE));
    drills.push_back(req_row(REQ_COUNT, '0, '0, 1'b1, 2, STAT_DONE));
    drills.push_back(req_row(REQ_COUNT, '0, TIME_W'(1), 1'b1, 0, STAT_DONE));
    // expired match, then time stepping back
    drills.push_back(req_row(REQ_RENEW, '0, TIME_W'(1), 1'b1, 0, STAT_NO_MATCH));
    drills.push_back(req_row(REQ_COUNT, KEY_ONES, '0, 1'b1, 2, STAT_DONE));
    // widest expiry: max time plus max TTL
    drills.push_back(cfg_row(TTL_MAX));
    drills.push_back(req_row(REQ_GENERATE, 40'h5A_5A5A_5A5A, NOW_MAX, 1'b1, 0, STAT_DONE));
    drills.push_back(req_row(REQ_COUNT, '0, NOW_MAX, 1'b1, 1, STAT_DONE));
    drills.push_back(req_row(REQ_RENEW, 40'h5A_5A5A_5A5A, NOW_MAX, 1'b1, 0, STAT_DONE));
    // duplicate key lands in another slot; renew hits the lowest one
    drills.push_back(req_row(REQ_GENERATE, '0, '0));
    drills.push_back(req_row(REQ_GENERATE, '0, '0));
    drills.push_back(req_row(REQ_RENEW, '0, '0));
    drills.push_back(req_row(REQ_COUNT, '0, '0));
    // zero TTL: entries expire immediately
    drills.push_back(cfg_row('0));
    drills.push_back(req_row(REQ_GENERATE, 40'h12_3456_789A, TIME_W'(100)));
    drills.push_back(req_row(REQ_COUNT, '0, TIME_W'(100)));
    drills.push_back(req_row(REQ_RENEW, 40'h12_3456_789A, TIME_W'(100)));
    drills.push_back(req_row(REQ_RENEW, 40'hA5_A5A5_A5A5, TIME_W'(100)));

    foreach (drills[n]) begin
      if (drills[n].kind == ROW_CFG) begin
        write_ttl(drills[n].ttl);
      end else begin
        send_word(drills[n].rq, drills[n].has_gold, drills[n].gold);
      end
    end

    for (int p = 0; p < 4; p++) begin
      write_ttl(phase_ttl[p]);
      foreach (key_pool[k]) key_pool[k] = KEY_BITS'({$urandom(), $urandom()});
      served = 0;
      while (served < RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          now = $urandom() & 32'h7FFF_FFFF;
        end else if (pick < 6) begin
          now = $urandom_range(now, 0);
        end else begin
          now = (now + $urandom_range(4, 0)) & 32'h7FFF_FFFF;
        end
        rq.current_time = TIME_W'(now);
        if ($urandom_range(9) == 0) begin
          rq.token_key = KEY_BITS'({$urandom(), $urandom()});
        end else begin
          rq.token_key = key_pool[$urandom_range(POOL_N - 1)];
        end
        pick = $urandom_range(99);
        rq.req_type = (pick < 38) ? REQ_GENERATE :
                      (pick < 72) ? REQ_RENEW :
                      (pick < 92) ? REQ_COUNT : REQ_UNUSED;
        if (rq.req_type != REQ_UNUSED) served++;
        while ($urandom_range(99) < idle_pct[p]) idle_cycle();
        send_word(rq, 1'b0, '0);
      end
    end

    // fill every slot with live entries, then hit the full table
    write_ttl(TTL_MAX);
    rq.req_type     = REQ_GENERATE;
    rq.current_time = '0;
    while (live_slots('0) < TABLE_DEPTH) begin
      rq.token_key = key_pool[$urandom_range(POOL_N - 1)];
      send_word(rq, 1'b0, '0);
    end
    row = req_row(REQ_GENERATE, KEY_ONES, '0, 1'b1, 0, STAT_FULL);
    send_word(row.rq, row.has_gold, row.gold);
    row = req_row(REQ_COUNT, '0, '0, 1'b1, TABLE_DEPTH, STAT_DONE);
    send_word(row.rq, row.has_gold, row.gold);
    row = req_row(REQ_RENEW, key_pool[0], '0);
    send_word(row.rq, 1'b0, '0);
    row = req_row(REQ_GENERATE, KEY_ONES, NOW_MAX);
    send_word(row.rq, 1'b0, '0);
    row = req_row(REQ_COUNT, '0, NOW_MAX);
    send_word(row.rq, 1'b0, '0);

    settle();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("ttl_token_expiry_table regression: pass");
    end else begin
      $display("ttl_token_expiry_table regression: fail");
    end
    $finish;
  end

endmodule
